// File: rtl/core/line_of_sight_obstruction_finder_assert.svh
`ifndef LINE_OF_SIGHT_OBSTRUCTION_FINDER_ASSERT_SVH
`define LINE_OF_SIGHT_OBSTRUCTION_FINDER_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define LOSOF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("losof check failed");

// next-cycle implication, checked on every rising edge outside reset
`define LOSOF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("losof check failed");

`endif

// File: rtl/core/losof_pkg.sv
package losof_pkg;

	// profile storage
	localparam int MAX_POINTS = 1024;
	localparam int ADDR_W     = $clog2(MAX_POINTS);
	localparam int CNT_W      = ADDR_W + 1;

	// field widths
	localparam int DIST_W   = 24;
	localparam int ELEV_W   = 24;
	localparam int HGT_W    = 20;
	localparam int FRAC_W   = 16;
	localparam int OIDX_W   = 10;
	localparam int OHGT_W   = 24;
	localparam int CFG_W    = 24;
	localparam int CIDX_W   = 2;

	// arithmetic widths
	localparam int END_W    = ELEV_W + 2;          // elevation plus antenna height
	localparam int DIFF_W   = END_W + 1;           // receiver end minus source end
	localparam int PROD_W   = FRAC_W + 1 + DIFF_W; // signed fraction times difference
	localparam int PSH_W    = PROD_W - FRAC_W;     // product scaled down by 2^16
	localparam int EXC_W    = PSH_W + 2;           // elevation minus sight height

	// register indexes
	localparam logic [CIDX_W-1:0] REG_SOURCE_HEIGHT   = 2'd0;
	localparam logic [CIDX_W-1:0] REG_RECEIVER_HEIGHT = 2'd1;
	localparam logic [CIDX_W-1:0] REG_TOTAL_DISTANCE  = 2'd2;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_START,
		ST_READ,
		ST_DSTART,
		ST_DIV,
		ST_EXC,
		ST_UPD,
		ST_DONE
	} state_t;

	// request to the fraction divider
	typedef struct packed {
		logic              start;
		logic [DIST_W-1:0] dividend;
		logic [DIST_W-1:0] divisor;
	} div_req_t;

	// answer from the fraction divider
	typedef struct packed {
		logic              done;
		logic [FRAC_W-1:0] frac;
	} div_rsp_t;

endpackage

// File: rtl/core/line_of_sight_obstruction_finder.sv
// channel | dir | beat contents (lowest bit first)
// s_axis  | in  | tdata: point_distance[23:0], point_elevation[47:24]; tlast: last_point
// m_axis  | out | tdata: obstruction_index[9:0], obstruction_height[33:10]; tuser: overflow
// cfg     | in  | cfg_idx 0 source_height, 1 receiver_height, 2 total_distance
//
// points load at one beat per cycle into a 1024 x 48 profile memory, save from a last
// beat until its result is registered; the last beat starts a scan: a setup step, then
// per interior point a memory read, the bit-serial fraction divider, the excess and the
// best update, then the result load; a profile under three points skips the loop
// arst_n clears control state; memory contents are left as they are
// a waiting result blocks only the next profile's result, not its loading
module line_of_sight_obstruction_finder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [23:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // point_distance, point_elevation
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // obstruction_index, obstruction_height, zero pad
	output logic        m_axis_tuser   // overflow
);

	localparam int AW  = losof_pkg::ADDR_W;
	localparam int CW  = losof_pkg::CNT_W;
	localparam int MW  = losof_pkg::DIST_W + losof_pkg::ELEV_W;
	localparam int XW  = losof_pkg::EXC_W;

	losof_pkg::state_t state_q, state_d;

	// configuration
	logic [losof_pkg::HGT_W-1:0]  src_hgt_q;
	logic [losof_pkg::HGT_W-1:0]  rcv_hgt_q;
	logic [losof_pkg::DIST_W-1:0] tot_dist_q;

	// profile state
	logic [MW-1:0] mem [losof_pkg::MAX_POINTS];
	logic [MW-1:0] rd_data_q;
	logic [CW-1:0] count_q;
	logic          dropped_q;
	logic signed [losof_pkg::ELEV_W-1:0] first_elev_q;
	logic signed [losof_pkg::ELEV_W-1:0] last_elev_q;

	// scan state
	logic [AW-1:0]                        idx_q;
	logic [AW-1:0]                        best_idx_q;
	logic signed [XW-1:0]                 best_q;
	logic signed [XW-1:0]                 excess_q;
	logic signed [losof_pkg::END_W-1:0]   src_end_q;
	logic signed [losof_pkg::DIFF_W-1:0]  diff_q;
	logic signed [losof_pkg::PROD_W-1:0]  prod_q;

	// output register
	logic                         out_valid_q;
	logic [losof_pkg::OIDX_W-1:0] out_idx_q;
	logic [losof_pkg::OHGT_W-1:0] out_hgt_q;
	logic                         out_ovf_q;

	logic                  in_beat;
	logic                  out_free;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic                  rd_en;
	logic                  room;
	logic                  last_interior;
	logic                  div_start;
	logic signed [losof_pkg::END_W-1:0]  src_end;
	logic signed [losof_pkg::END_W-1:0]  rcv_end;
	logic signed [losof_pkg::PSH_W-1:0]  prod_sh;
	logic signed [losof_pkg::ELEV_W-1:0] rd_elev;
	losof_pkg::div_req_t div_req;
	losof_pkg::div_rsp_t div_rsp;

	assign in_beat  = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;
	assign room     = (count_q < CW'(losof_pkg::MAX_POINTS));

	// store while there is room; a last point on a full store takes the final slot
	assign wr_en   = in_beat && (room || s_axis_tlast);
	assign wr_addr = room ? count_q[AW-1:0] : AW'(losof_pkg::MAX_POINTS - 1);

	// sight line end points
	assign src_end = losof_pkg::END_W'(first_elev_q)
	               + losof_pkg::END_W'($signed({1'b0, src_hgt_q}));
	assign rcv_end = losof_pkg::END_W'(last_elev_q)
	               + losof_pkg::END_W'($signed({1'b0, rcv_hgt_q}));

	assign prod_sh       = prod_q[losof_pkg::PROD_W-1:losof_pkg::FRAC_W];
	assign rd_elev       = rd_data_q[MW-1:losof_pkg::DIST_W];
	assign last_interior = ({1'b0, idx_q} + CW'(2) == count_q);

	// fraction divider
	assign div_req.start    = div_start;
	assign div_req.dividend = rd_data_q[losof_pkg::DIST_W-1:0];
	assign div_req.divisor  = tot_dist_q;

	losof_frac_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_hgt_q  <= '0;
			rcv_hgt_q  <= '0;
			tot_dist_q <= losof_pkg::DIST_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				losof_pkg::REG_SOURCE_HEIGHT:   src_hgt_q  <= cfg_data[losof_pkg::HGT_W-1:0];
				losof_pkg::REG_RECEIVER_HEIGHT: rcv_hgt_q  <= cfg_data[losof_pkg::HGT_W-1:0];
				losof_pkg::REG_TOTAL_DISTANCE:  tot_dist_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// profile memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[idx_q];
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= losof_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and strobes
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		rd_en         = 1'b0;
		div_start     = 1'b0;
		unique case (state_q)
			losof_pkg::ST_LOAD: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid && s_axis_tlast) begin
					state_d = losof_pkg::ST_START;
				end
			end
			losof_pkg::ST_START: begin
				state_d = (count_q < CW'(3)) ? losof_pkg::ST_DONE : losof_pkg::ST_READ;
			end
			losof_pkg::ST_READ: begin
				rd_en   = 1'b1;
				state_d = losof_pkg::ST_DSTART;
			end
			losof_pkg::ST_DSTART: begin
				div_start = 1'b1;
				state_d   = losof_pkg::ST_DIV;
			end
			losof_pkg::ST_DIV: begin
				if (div_rsp.done) begin
					state_d = losof_pkg::ST_EXC;
				end
			end
			losof_pkg::ST_EXC: begin
				state_d = losof_pkg::ST_UPD;
			end
			losof_pkg::ST_UPD: begin
				state_d = last_interior ? losof_pkg::ST_DONE : losof_pkg::ST_READ;
			end
			losof_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = losof_pkg::ST_LOAD;
				end
			end
			default: state_d = losof_pkg::ST_LOAD;
		endcase
	end

	// count, overflow, scan index, best excess and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			dropped_q   <= 1'b0;
			idx_q       <= '0;
			best_q      <= '0;
			best_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == losof_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (in_beat) begin
				if (room) begin
					count_q <= count_q + CW'(1);
				end else begin
					dropped_q <= 1'b1;
				end
			end
			if (state_q == losof_pkg::ST_START) begin
				idx_q      <= AW'(1);
				best_q     <= '0;
				best_idx_q <= '0;
			end
			if (state_q == losof_pkg::ST_UPD) begin
				if (excess_q > best_q) begin
					best_q     <= excess_q;
					best_idx_q <= idx_q;
				end
				idx_q <= idx_q + AW'(1);
			end
			if (state_q == losof_pkg::ST_DONE && out_free) begin
				count_q   <= '0;
				dropped_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_beat && count_q == '0) begin
			first_elev_q <= s_axis_tdata[MW-1:losof_pkg::DIST_W];
		end
		if (in_beat && s_axis_tlast) begin
			last_elev_q <= s_axis_tdata[MW-1:losof_pkg::DIST_W];
		end
		if (state_q == losof_pkg::ST_START) begin
			src_end_q <= src_end;
			diff_q    <= losof_pkg::DIFF_W'(rcv_end) - losof_pkg::DIFF_W'(src_end);
		end
		if (state_q == losof_pkg::ST_DIV && div_rsp.done) begin
			prod_q <= $signed({1'b0, div_rsp.frac}) * diff_q;
		end
		if (state_q == losof_pkg::ST_EXC) begin
			excess_q <= XW'(rd_elev) - XW'(src_end_q) - XW'(prod_sh);
		end
		if (state_q == losof_pkg::ST_DONE && out_free) begin
			out_idx_q <= losof_pkg::OIDX_W'(best_idx_q);
			out_hgt_q <= (best_q > $signed(XW'(24'hFFFFFF))) ? '1
			                                                 : best_q[losof_pkg::OHGT_W-1:0];
			out_ovf_q <= dropped_q;
		end
	end

	// result beat
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_hgt_q, out_idx_q};
	assign m_axis_tuser  = out_ovf_q;

endmodule

// File: rtl/core/losof_frac_div.sv
module losof_frac_div (
	input  logic                clk,
	input  logic                arst_n,
	input  losof_pkg::div_req_t req,
	output losof_pkg::div_rsp_t rsp
);

	localparam int CW = $clog2(losof_pkg::FRAC_W);

	logic [losof_pkg::DIST_W-1:0] rem_q;
	logic [losof_pkg::DIST_W-1:0] dvs_q;
	logic [losof_pkg::FRAC_W-1:0] quot_q;
	logic [CW-1:0]                cnt_q;
	logic                         busy_q;
	logic                         done_q;
	logic                         sat_q;
	logic [losof_pkg::DIST_W-1:0] dvs_eff;
	logic [losof_pkg::DIST_W:0]   shifted;
	logic                         qbit;

	// zero divisor behaves as one
	assign dvs_eff = (req.divisor == '0) ? losof_pkg::DIST_W'(1) : req.divisor;

	// one restoring step per cycle while busy
	assign shifted = {rem_q, 1'b0};
	assign qbit    = (shifted >= {1'b0, dvs_q});

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !req.start && (cnt_q == '0);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(losof_pkg::FRAC_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// remainder and quotient
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.dividend;
			dvs_q  <= dvs_eff;
			sat_q  <= (req.dividend >= dvs_eff);
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= qbit ? losof_pkg::DIST_W'(shifted - {1'b0, dvs_q})
			               : shifted[losof_pkg::DIST_W-1:0];
			quot_q <= {quot_q[losof_pkg::FRAC_W-2:0], qbit};
		end
	end

	// fraction of one or more saturates
	assign rsp.done = done_q;
	assign rsp.frac = sat_q ? '1 : quot_q;

endmodule

// File: rtl/core/losof_checker.sv
`include "line_of_sight_obstruction_finder_assert.svh"

module losof_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	// a stalled result beat holds
	`LOSOF_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

	// the last point starts a scan, so no point is taken in the next cycle
	`LOSOF_ASSERT_NEXT(a_scan_blocks_input, clk, arst_n, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready)

	// a zero excess always reports index zero
	`LOSOF_ASSERT_NOW(a_zero_height_zero_idx, clk, arst_n, m_axis_tvalid && m_axis_tdata[33:10] == 24'd0, m_axis_tdata[9:0] == 10'd0)

	// a new result only appears at the end of a scan, when input was held off
	`LOSOF_ASSERT_NOW(a_result_after_scan, clk, arst_n, $rose(m_axis_tvalid), !$past(s_axis_tready))

endmodule

bind line_of_sight_obstruction_finder losof_checker u_losof_checker (.*);
